### hw/rtl/hela_pkg.sv
// Package for the heading-error lateral acceleration block.
// Holds the polynomial constants, reset values and quadrant codes.
// No dependencies.
package hela_pkg;

    localparam int ANGLE_BITS_DEF = 16;

    // Odd fifth-order quarter-sine polynomial, all values in Q16.
    localparam logic [16:0] SIN_A   = 17'd102944;
    localparam logic [15:0] SIN_B   = 16'd42048;
    localparam logic [12:0] SIN_C   = 13'd4640;
    localparam logic [16:0] Q16_ONE = 17'd65536;

    localparam logic [15:0] GAIN_RESET = 16'd256;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam int QSIN_STAGES = 4;

endpackage

### hw/rtl/heading_error_lateral_accel.sv
// Top level of the heading-error lateral acceleration block.
// Depends on hela_pkg and hela_qsin.
//
// Use: an input beat carries heading setpoint, current heading (binary angles)
// and airspeed (unsigned Q8.8). An output beat carries the lateral acceleration
// command, signed Q.8. Both channels use valid/ready. The gain register is
// written through its own valid/ready channel, which is always ready; it should
// only be written while no beats are in flight.
// One beat can be taken every cycle while the receiver keeps accepting: eight
// register stages, each with its own valid bit, carry the work (angle reduction
// and gain product, four polynomial stages, quadrant selection, the final
// product, rounding and sign). When the receiver stalls, each stage holds only
// while the stage after it is full, so bubbles close up and input ready falls
// only once all eight stages hold a beat. Synchronous reset empties the
// pipeline and sets the gain to 1.0.
module heading_error_lateral_accel
    import hela_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [15:0]        i_heading_target,
    input  logic [15:0]        i_heading_now,
    input  logic [15:0]        i_air_speed,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [25:0] o_lateral_accel,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_lateral_gain
);

    localparam int NSTG       = 8;
    localparam int UP_SHIFT   = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
    localparam int DOWN_SHIFT = (ANGLE_BITS >= 16) ? 0 : 16 - ANGLE_BITS;
    localparam int FRAC_UP    = (ANGLE_BITS <= 18) ? 18 - ANGLE_BITS : 0;
    localparam int FRAC_DOWN  = (ANGLE_BITS > 18) ? ANGLE_BITS - 18 : 0;

    logic [15:0]     r_gain;
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_en;

    // Stage 0
    logic [15:0] n_e16;
    logic [47:0] n_pw;
    logic [ANGLE_BITS-1:0] n_p;
    logic [47:0] n_xw;
    logic [15:0] r_x0;
    logic [1:0]  r_q0;
    logic [31:0] r_gs0;
    logic        r_nz0;

    // Stages 1 to 4 run alongside the polynomial units.
    logic [1:0]  r_q_p  [QSIN_STAGES];
    logic [31:0] r_gs_p [QSIN_STAGES];
    logic        r_nz_p [QSIN_STAGES];
    logic [16:0] n_sx, n_cx;

    // Stages 5 to 7
    logic [16:0] r_abs5;
    logic        r_neg5, r_hold5;
    logic [31:0] r_gs5;
    logic [48:0] r_prod6;
    logic [24:0] r_hmag6;
    logic        r_neg6, r_hold6;
    logic signed [25:0] r_out7;

    logic [1:0]  n_q4;
    logic [32:0] n_hsum;
    logic [49:0] n_rsum;
    logic [24:0] n_mag;

    always_comb begin
        n_en[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            n_en[k] = !r_vld[k] || n_en[k+1];
        end
    end

    assign o_ready     = n_en[0];
    assign o_valid     = r_vld[NSTG-1];
    assign o_cfg_ready = 1'b1;
    assign o_lateral_accel = r_out7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg_valid) begin
            r_gain <= i_lateral_gain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (n_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Angle reduction: quadrant from the top two bits, the rest a Q16 fraction.
    always_comb begin
        n_e16 = i_heading_target - i_heading_now;
        n_pw  = (48'(n_e16) << UP_SHIFT) >> DOWN_SHIFT;
        n_p   = n_pw[ANGLE_BITS-1:0];
        n_xw  = (48'(n_p[ANGLE_BITS-3:0]) << FRAC_UP) >> FRAC_DOWN;
    end

    always_ff @(posedge i_clk) begin
        if (n_en[0]) begin
            r_x0  <= n_xw[15:0];
            r_q0  <= n_p[ANGLE_BITS-1 -: 2];
            r_gs0 <= 32'(r_gain) * 32'(i_air_speed);
            r_nz0 <= (i_air_speed != 16'd0);
        end
        if (n_en[1]) begin
            r_q_p[0]  <= r_q0;
            r_gs_p[0] <= r_gs0;
            r_nz_p[0] <= r_nz0;
        end
        for (int k = 1; k < QSIN_STAGES; k++) begin
            if (n_en[k+1]) begin
                r_q_p[k]  <= r_q_p[k-1];
                r_gs_p[k] <= r_gs_p[k-1];
                r_nz_p[k] <= r_nz_p[k-1];
            end
        end
    end

    hela_qsin u_sin (
        .i_clk (i_clk),
        .i_en  (n_en[QSIN_STAGES:1]),
        .i_x   ({1'b0, r_x0}),
        .o_s   (n_sx)
    );

    hela_qsin u_cos (
        .i_clk (i_clk),
        .i_en  (n_en[QSIN_STAGES:1]),
        .i_x   (Q16_ONE - {1'b0, r_x0}),
        .o_s   (n_cx)
    );

    assign n_q4 = r_q_p[QSIN_STAGES-1];

    // Quadrant selection. The cross term is negative in the lower half turn,
    // the dot term negative in the second and third quadrants.
    always_ff @(posedge i_clk) begin
        if (n_en[5]) begin
            r_gs5 <= r_gs_p[QSIN_STAGES-1];
            case (n_q4)
                QUAD_0: begin
                    r_abs5  <= n_sx;
                    r_neg5  <= 1'b0;
                    r_hold5 <= 1'b0;
                end
                QUAD_1: begin
                    r_abs5  <= n_cx;
                    r_neg5  <= 1'b0;
                    r_hold5 <= r_nz_p[QSIN_STAGES-1] && (n_sx != 17'd0);
                end
                QUAD_2: begin
                    r_abs5  <= n_sx;
                    r_neg5  <= (n_sx != 17'd0);
                    r_hold5 <= r_nz_p[QSIN_STAGES-1] && (n_cx != 17'd0);
                end
                QUAD_3: begin
                    r_abs5  <= n_cx;
                    r_neg5  <= (n_cx != 17'd0);
                    r_hold5 <= 1'b0;
                end
                default: begin
                    r_abs5  <= n_sx;
                    r_neg5  <= 1'b0;
                    r_hold5 <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_hsum = 33'(r_gs5) + 33'd128;
        n_rsum = 50'(r_prod6) + (50'd1 << 23);
        n_mag  = r_hold6 ? r_hmag6 : n_rsum[48:24];
    end

    always_ff @(posedge i_clk) begin
        if (n_en[6]) begin
            r_prod6 <= 49'(r_gs5) * 49'(r_abs5);
            r_hmag6 <= n_hsum[32:8];
            r_neg6  <= r_neg5;
            r_hold6 <= r_hold5;
        end
        if (n_en[7]) begin
            r_out7 <= r_neg6 ? -$signed({1'b0, n_mag}) : $signed({1'b0, n_mag});
        end
    end

    // Input ready may only fall when every stage holds a beat.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_vld))
        else $error("input stalled while the pipeline had a bubble");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_lateral_accel <= 26'sd16777216)
                    && (o_lateral_accel >= -26'sd16777216))
        else $error("lateral acceleration out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("output valid straight after reset");

endmodule

### hw/rtl/hela_qsin.sv
// Four-stage pipelined quarter-sine polynomial, S(x) for x in 0..1 (Q16).
// One multiplier per stage; each stage loads on its own enable bit.
// Depends on hela_pkg.
module hela_qsin
    import hela_pkg::*;
(
    input  logic                   i_clk,
    input  logic [QSIN_STAGES-1:0] i_en,
    input  logic [16:0]            i_x,
    output logic [16:0]            o_s
);

    logic [16:0] r_x_a, r_x_b, r_x_c;
    logic [16:0] r_x2, r_x2_b;
    logic [15:0] r_t;
    logic [16:0] r_u;
    logic [16:0] r_s;

    logic [33:0] n_sq;
    logic [29:0] n_tp;
    logic [32:0] n_up;
    logic [33:0] n_sp;
    logic [17:0] n_sraw;

    always_comb begin
        n_sq   = 34'(i_x) * 34'(i_x);
        n_tp   = 30'(r_x2) * 30'(SIN_C);
        n_up   = 33'(r_x2_b) * 33'(r_t);
        n_sp   = 34'(r_x_c) * 34'(r_u);
        n_sraw = n_sp[33:16];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x_a <= i_x;
            r_x2  <= n_sq[32:16];
        end
        if (i_en[1]) begin
            r_x_b  <= r_x_a;
            r_x2_b <= r_x2;
            r_t    <= SIN_B - 16'(n_tp[29:16]);
        end
        if (i_en[2]) begin
            r_x_c <= r_x_b;
            r_u   <= SIN_A - 17'(n_up[32:16]);
        end
        if (i_en[3]) begin
            // The polynomial overshoots slightly near a quarter turn.
            r_s <= (n_sraw > 18'(Q16_ONE)) ? Q16_ONE : n_sraw[16:0];
        end
    end

    assign o_s = r_s;

endmodule
